/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be true.
`define LSFP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* rtl/lsfp_pkg.sv */
// ----------------------------------------------------------------------------
// lsfp_pkg
// Types, codes and constants shared by the line sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfp_pkg;

  // Default sizes handed to the top level parameters.
  localparam int REFLECTOR_COUNT_DEF = 16;
  localparam int MAX_TOKENS_DEF      = 30;

  // Line jobs that may wait between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Characters the parser cares about.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // Token magnitude ceiling (the negative limit) and positive ceiling.
  localparam logic [16:0] TOKEN_SAT     = 17'd32768;
  localparam logic [16:0] TOKEN_POS_MAX = 17'd32767;

  // Result kinds.
  localparam logic [1:0] KIND_REFLECTOR = 2'd0;
  localparam logic [1:0] KIND_LEFT      = 2'd1;
  localparam logic [1:0] KIND_RIGHT     = 2'd2;

  // Color classes.
  localparam logic [1:0] CLASS_BLACK = 2'd0;
  localparam logic [1:0] CLASS_WHITE = 2'd1;
  localparam logic [1:0] CLASS_GREEN = 2'd2;
  localparam logic [1:0] CLASS_RED   = 2'd3;

  // Configuration register indexes and port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;
  localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_RATIO     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLACK_LIMIT_CH0 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLACK_LIMIT_CH1 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_VALID_MAX = 2'd3;

  // Configuration reset values.
  localparam logic [3:0]  GREEN_RATIO_RST     = 4'd3;
  localparam logic [9:0]  BLACK_LIMIT_CH0_RST = 10'd10;
  localparam logic [9:0]  BLACK_LIMIT_CH1_RST = 10'd20;
  localparam logic [14:0] COLOR_VALID_MAX_RST = 15'd100;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    logic [3:0]  green_ratio;
    logic [9:0]  black_limit_ch0;
    logic [9:0]  black_limit_ch1;
    logic [14:0] color_valid_max;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         item_kind;
    logic [3:0]         channel_index;
    logic signed [15:0] reading;
    logic [1:0]         color_class;
    logic               repeated;
    logic [31:0]        class_stamp;
    logic               last_of_run;
  } out_item_t;

  // Classification result of one side.
  typedef struct packed {
    logic [1:0]  color_class;
    logic        repeated;
    logic [31:0] class_stamp;
  } color_res_t;

  typedef struct packed {
    color_res_t left;
    color_res_t right;
  } color_job_t;

  // Queue fill status seen by the front and the back.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_status_t;

endpackage

`default_nettype wire

/* rtl/lsfp_stream_if.sv */
// ----------------------------------------------------------------------------
// lsfp_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfp_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/lsfp_front.sv */
// ----------------------------------------------------------------------------
// lsfp_front
// Byte parser: line sync, token assembly, store updates and tick counting.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfp_front #(
  parameter int REFLECTOR_COUNT = lsfp_pkg::REFLECTOR_COUNT_DEF,
  parameter int MAX_TOKENS      = lsfp_pkg::MAX_TOKENS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  lsfp_stream_if.sink              in_bus,
  input  wire lsfp_pkg::cfg_t      cfg,
  input  wire lsfp_pkg::q_status_t q_status,
  output lsfp_pkg::sample_t        refl_store [REFLECTOR_COUNT],
  output lsfp_pkg::sample_t        color_ch [6],
  output logic [31:0]              tick_count,
  output logic                     line_done
);

  localparam int TC_W = $clog2(MAX_TOKENS + 1);

  lsfp_pkg::in_item_t in_item;
  logic               accept;
  logic [7:0]         b;
  logic               is_digit;
  logic [7:0]         dsub;
  logic [lsfp_pkg::QCNT_W:0] used;

  logic            synced_r, synced_nxt;
  logic            in_tok_r, in_tok_nxt;
  logic            neg_r, neg_nxt;
  logic            stop_r, stop_nxt;
  logic [16:0]     acc_r, acc_nxt;
  logic [TC_W-1:0] tok_cnt_r, tok_cnt_nxt;
  logic [31:0]     tick_r, tick_nxt;
  logic            line_done_r, line_done_nxt;
  lsfp_pkg::sample_t refl_r [REFLECTOR_COUNT];
  lsfp_pkg::sample_t refl_nxt [REFLECTOR_COUNT];
  lsfp_pkg::sample_t color_r [6];
  lsfp_pkg::sample_t color_nxt [6];

  logic              commit;
  logic              cur_stop;
  logic [16:0]       cur_acc;
  logic [19:0]       acc_sum;
  logic [16:0]       acc_sat;
  logic [16:0]       neg_mag;
  lsfp_pkg::sample_t commit_val;
  logic              color_ok;
  logic [7:0]        tc8;
  logic              idx_ok;

  // Accept only when the queue has room for a line that this word may end.
  assign used = {1'b0, q_status.count} + (lsfp_pkg::QCNT_W + 1)'(line_done_r);
  assign in_bus.ready = used < (lsfp_pkg::QCNT_W + 1)'(lsfp_pkg::QUEUE_DEPTH);
  assign accept  = in_bus.valid && in_bus.ready;
  assign in_item = in_bus.payload;
  assign b       = in_item.rx_byte;
  assign is_digit = (b >= lsfp_pkg::CHAR_ZERO) && (b <= lsfp_pkg::CHAR_NINE);
  assign dsub    = b - lsfp_pkg::CHAR_ZERO;

  // A token that starts with this word begins from a cleared state.
  assign cur_stop = in_tok_r ? stop_r : 1'b0;
  assign cur_acc  = in_tok_r ? acc_r : 17'd0;

  // Decimal step: acc * 10 + digit, clamped to the negative ceiling.
  assign acc_sum = ({3'b000, cur_acc} << 3) + ({3'b000, cur_acc} << 1) + {16'd0, dsub[3:0]};
  assign acc_sat = (acc_sum > {3'b000, lsfp_pkg::TOKEN_SAT}) ? lsfp_pkg::TOKEN_SAT
                                                           : acc_sum[16:0];

  // Signed value of the finished token; the magnitude never exceeds 32768.
  assign neg_mag = 17'd0 - acc_r;
  always_comb begin
    if (neg_r) begin
      commit_val = neg_mag[15:0];
    end else if (acc_r > lsfp_pkg::TOKEN_POS_MAX) begin
      commit_val = lsfp_pkg::TOKEN_POS_MAX[15:0];
    end else begin
      commit_val = acc_r[15:0];
    end
  end

  assign color_ok = $signed({commit_val[15], commit_val})
                    <= $signed({2'b00, cfg.color_valid_max});
  assign tc8    = 8'(tok_cnt_r);
  assign idx_ok = tc8 < 8'(MAX_TOKENS);

  // Next state for one accepted word.
  always_comb begin
    synced_nxt    = synced_r;
    in_tok_nxt    = in_tok_r;
    neg_nxt       = neg_r;
    stop_nxt      = stop_r;
    acc_nxt       = acc_r;
    tok_cnt_nxt   = tok_cnt_r;
    tick_nxt      = tick_r;
    line_done_nxt = 1'b0;
    commit        = 1'b0;
    refl_nxt      = refl_r;
    color_nxt     = color_r;

    if (accept) begin
      if (in_item.operation == lsfp_pkg::OP_TICK) begin
        tick_nxt = tick_r + 32'd1;
      end else if (!synced_r) begin
        if (b == lsfp_pkg::CHAR_NEWLINE) begin
          synced_nxt = 1'b1;
        end
      end else if (b == lsfp_pkg::CHAR_SPACE || b == lsfp_pkg::CHAR_NEWLINE) begin
        commit        = in_tok_r;
        line_done_nxt = (b == lsfp_pkg::CHAR_NEWLINE);
      end else if (!in_tok_r && b == lsfp_pkg::CHAR_MINUS) begin
        in_tok_nxt = 1'b1;
        neg_nxt    = 1'b1;
        stop_nxt   = 1'b0;
        acc_nxt    = 17'd0;
      end else begin
        in_tok_nxt = 1'b1;
        if (!in_tok_r) begin
          neg_nxt  = 1'b0;
          stop_nxt = 1'b0;
          acc_nxt  = 17'd0;
        end
        if (!cur_stop) begin
          if (is_digit) begin
            acc_nxt = acc_sat;
          end else begin
            stop_nxt = 1'b1;
            acc_nxt  = cur_acc;
          end
        end
      end
    end

    // Store the finished token and move to the next slot.
    if (commit) begin
      for (int i = 0; i < REFLECTOR_COUNT; i++) begin
        if (idx_ok && tc8 == 8'(i)) begin
          refl_nxt[i] = commit_val;
        end
      end
      for (int j = 0; j < 6; j++) begin
        if (idx_ok && color_ok && tc8 == 8'(REFLECTOR_COUNT + j)) begin
          color_nxt[j] = commit_val;
        end
      end
      in_tok_nxt = 1'b0;
      neg_nxt    = 1'b0;
      stop_nxt   = 1'b0;
      acc_nxt    = 17'd0;
      if (tok_cnt_r < TC_W'(MAX_TOKENS)) begin
        tok_cnt_nxt = tok_cnt_r + 1'b1;
      end
    end

    // A newline starts the next line at token zero.
    if (line_done_nxt) begin
      tok_cnt_nxt = '0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r    <= 1'b0;
      in_tok_r    <= 1'b0;
      neg_r       <= 1'b0;
      stop_r      <= 1'b0;
      acc_r       <= 17'd0;
      tok_cnt_r   <= '0;
      tick_r      <= 32'd0;
      line_done_r <= 1'b0;
      for (int i = 0; i < REFLECTOR_COUNT; i++) begin
        refl_r[i] <= '0;
      end
      for (int j = 0; j < 6; j++) begin
        color_r[j] <= '0;
      end
    end else begin
      synced_r    <= synced_nxt;
      in_tok_r    <= in_tok_nxt;
      neg_r       <= neg_nxt;
      stop_r      <= stop_nxt;
      acc_r       <= acc_nxt;
      tok_cnt_r   <= tok_cnt_nxt;
      tick_r      <= tick_nxt;
      line_done_r <= line_done_nxt;
      refl_r      <= refl_nxt;
      color_r     <= color_nxt;
    end
  end

  assign refl_store = refl_r;
  assign color_ch   = color_r;
  assign tick_count = tick_r;
  assign line_done  = line_done_r;

endmodule

`default_nettype wire

/* rtl/lsfp_classify.sv */
// ----------------------------------------------------------------------------
// lsfp_classify
// Classifies both color sides at the end of a line and keeps class history.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfp_classify (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               line_done,
  input  wire lsfp_pkg::sample_t  color_ch [6],
  input  wire logic [31:0]        tick_count,
  input  wire lsfp_pkg::cfg_t     cfg,
  output logic                    push,
  output lsfp_pkg::color_job_t    push_color
);

  lsfp_pkg::color_res_t res [2];

  // Side 0 is left (channels 3 and 4), side 1 is right (channels 0 and 1).
  for (genvar s = 0; s < 2; s++) begin : g_side
    localparam int BASE = (s == 0) ? 3 : 0;

    lsfp_pkg::sample_t  c0;
    lsfp_pkg::sample_t  c1;
    logic signed [20:0] prod;
    logic               is_green;
    logic               is_black;
    logic               is_red;
    logic [1:0]         cls;
    logic               rep;
    logic               prev_vld_r;
    logic [1:0]         prev_cls_r;
    logic [31:0]        stamps_r [4];

    assign c0   = color_ch[BASE];
    assign c1   = color_ch[BASE + 1];
    assign prod = c0 * $signed({1'b0, cfg.green_ratio});

    assign is_green = prod < $signed({{5{c1[15]}}, c1});
    assign is_black = ($signed({c0[15], c0}) < $signed({7'd0, cfg.black_limit_ch0})) &&
                      ($signed({c1[15], c1}) < $signed({7'd0, cfg.black_limit_ch1}));
    assign is_red   = c0 > c1;

    // Green wins over black, black over red, white is the rest.
    always_comb begin
      priority if (is_green) begin
        cls = lsfp_pkg::CLASS_GREEN;
      end else if (is_black) begin
        cls = lsfp_pkg::CLASS_BLACK;
      end else if (is_red) begin
        cls = lsfp_pkg::CLASS_RED;
      end else begin
        cls = lsfp_pkg::CLASS_WHITE;
      end
    end

    assign rep = prev_vld_r && (prev_cls_r == cls);

    // A repeated class takes the current tick count as its stamp.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        prev_vld_r <= 1'b0;
        prev_cls_r <= lsfp_pkg::CLASS_BLACK;
        for (int k = 0; k < 4; k++) begin
          stamps_r[k] <= 32'd0;
        end
      end else if (line_done) begin
        if (rep) begin
          stamps_r[cls] <= tick_count;
        end else begin
          prev_vld_r <= 1'b1;
          prev_cls_r <= cls;
        end
      end
    end

    assign res[s].color_class = cls;
    assign res[s].repeated    = rep;
    assign res[s].class_stamp = rep ? tick_count : stamps_r[cls];
  end

  assign push             = line_done;
  assign push_color.left  = res[0];
  assign push_color.right = res[1];

endmodule

`default_nettype wire

/* rtl/lsfp_queue.sv */
// ----------------------------------------------------------------------------
// lsfp_queue
// Short queue of finished lines: reflector snapshot plus both color results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsfp_queue #(
  parameter int REFLECTOR_COUNT = lsfp_pkg::REFLECTOR_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lsfp_pkg::sample_t    push_refl [REFLECTOR_COUNT],
  input  wire lsfp_pkg::color_job_t push_color,
  input  wire logic                 pop,
  input  wire logic [((REFLECTOR_COUNT > 1) ? $clog2(REFLECTOR_COUNT) : 1)-1:0] refl_sel,
  output lsfp_pkg::sample_t         head_refl,
  output lsfp_pkg::color_job_t      head_color,
  output lsfp_pkg::q_status_t       q_status
);

  localparam int DEPTH = lsfp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lsfp_pkg::sample_t    refl_q [DEPTH][REFLECTOR_COUNT];
  lsfp_pkg::color_job_t color_q [DEPTH];

  logic [PTR_W-1:0]            wr_ptr_r;
  logic [PTR_W-1:0]            rd_ptr_r;
  logic [lsfp_pkg::QCNT_W-1:0] count_r;
  logic                        full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = count_r == lsfp_pkg::QCNT_W'(DEPTH);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < REFLECTOR_COUNT; i++) begin
        refl_q[wr_ptr_r][i] <= push_refl[i];
      end
      color_q[wr_ptr_r] <= push_color;
    end
  end

  assign head_refl      = refl_q[rd_ptr_r][refl_sel];
  assign head_color     = color_q[rd_ptr_r];
  assign q_status.count = count_r;
  assign q_status.empty = count_r == '0;

  `LSFP_ASSERT_NEVER(a_no_overflow, push && full && !pop, "line pushed into a full queue")
  `LSFP_ASSERT_NEVER(a_no_underflow, pop && (count_r == '0), "line popped from an empty queue")
  `LSFP_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "fill count did not rise on push")

endmodule

`default_nettype wire

/* rtl/lsfp_back.sv */
// ----------------------------------------------------------------------------
// lsfp_back
// Emits the result run of the head line: reflectors, left color, right color.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lsfp_back #(
  parameter int REFLECTOR_COUNT = lsfp_pkg::REFLECTOR_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lsfp_stream_if.source             out_bus,
  input  wire lsfp_pkg::q_status_t  q_status,
  input  wire lsfp_pkg::sample_t    head_refl,
  input  wire lsfp_pkg::color_job_t head_color,
  output logic                      pop,
  output logic [((REFLECTOR_COUNT > 1) ? $clog2(REFLECTOR_COUNT) : 1)-1:0] refl_sel
);

  localparam int RI_W = (REFLECTOR_COUNT > 1) ? $clog2(REFLECTOR_COUNT) : 1;
  localparam int EI_W = $clog2(REFLECTOR_COUNT + 2);

  logic [EI_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  lsfp_pkg::out_item_t out_item_r, out_item_nxt;
  logic               load;
  logic [7:0]         ei8;

  // Load when a line is queued and the output register is empty or being taken.
  assign load     = !q_status.empty && (!out_valid_r || out_bus.ready);
  assign ei8      = 8'(emit_idx_r);
  assign refl_sel = ei8[RI_W-1:0];

  always_comb begin
    out_item_nxt = out_item_r;
    emit_idx_nxt = emit_idx_r;
    pop          = 1'b0;
    if (load) begin
      out_item_nxt = '0;
      if (emit_idx_r < EI_W'(REFLECTOR_COUNT)) begin
        out_item_nxt.item_kind     = lsfp_pkg::KIND_REFLECTOR;
        out_item_nxt.channel_index = ei8[3:0];
        out_item_nxt.reading       = head_refl;
        emit_idx_nxt               = emit_idx_r + 1'b1;
      end else if (emit_idx_r == EI_W'(REFLECTOR_COUNT)) begin
        out_item_nxt.item_kind   = lsfp_pkg::KIND_LEFT;
        out_item_nxt.color_class = head_color.left.color_class;
        out_item_nxt.repeated    = head_color.left.repeated;
        out_item_nxt.class_stamp = head_color.left.class_stamp;
        emit_idx_nxt             = emit_idx_r + 1'b1;
      end else begin
        // Right color closes the run and frees the queue entry.
        out_item_nxt.item_kind   = lsfp_pkg::KIND_RIGHT;
        out_item_nxt.color_class = head_color.right.color_class;
        out_item_nxt.repeated    = head_color.right.repeated;
        out_item_nxt.class_stamp = head_color.right.class_stamp;
        out_item_nxt.last_of_run = 1'b1;
        emit_idx_nxt             = '0;
        pop                      = 1'b1;
      end
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.payload = out_item_r;

  `LSFP_ASSERT_IMP(a_last_is_right, out_valid_r && out_item_r.last_of_run, out_item_r.item_kind == lsfp_pkg::KIND_RIGHT, "run ended on a word that is not the right color")
  `LSFP_ASSERT_NEVER(a_idx_range, emit_idx_r > EI_W'(REFLECTOR_COUNT + 1), "emit index past the right color")
  `LSFP_ASSERT_NEXT(a_pop_rewinds, pop, emit_idx_r == '0 && out_valid_r, "pop did not rewind the emit index")

endmodule

`default_nettype wire

/* rtl/line_sensor_frame_parser.sv */
// ----------------------------------------------------------------------------
// line_sensor_frame_parser
// Parses serial sensor lines into reflector values and classified colors.
//
//   Channel  Dir  Handshake        Word
//   in_bus   in   valid / ready    operation, rx_byte
//   out_bus  out  valid / ready    kind, index, reading, class, repeat, stamp, last
//   cfg_*    in   write enable     register index, data
//
// One input word is taken per cycle while in_bus.ready is high; bytes and ticks
// never wait on parsing. A newline yields REFLECTOR_COUNT + 2 result words, one
// per cycle from the output register while out_bus.ready is high. Input stalls
// only while the two-entry line queue, counting a line still in classification,
// is full. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_frame_parser #(
  parameter int REFLECTOR_COUNT = lsfp_pkg::REFLECTOR_COUNT_DEF,
  parameter int MAX_TOKENS      = lsfp_pkg::MAX_TOKENS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lsfp_stream_if.sink                            in_bus,
  lsfp_stream_if.source                          out_bus,
  input  wire logic                              cfg_we,
  input  wire logic [lsfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lsfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int RI_W = (REFLECTOR_COUNT > 1) ? $clog2(REFLECTOR_COUNT) : 1;

  lsfp_pkg::cfg_t       cfg_r;
  lsfp_pkg::sample_t    refl_store [REFLECTOR_COUNT];
  lsfp_pkg::sample_t    color_ch [6];
  logic [31:0]          tick_count;
  logic                 line_done;
  logic                 push;
  lsfp_pkg::color_job_t push_color;
  logic                 pop;
  logic [RI_W-1:0]      refl_sel;
  lsfp_pkg::sample_t    head_refl;
  lsfp_pkg::color_job_t head_color;
  lsfp_pkg::q_status_t  q_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_ratio     <= lsfp_pkg::GREEN_RATIO_RST;
      cfg_r.black_limit_ch0 <= lsfp_pkg::BLACK_LIMIT_CH0_RST;
      cfg_r.black_limit_ch1 <= lsfp_pkg::BLACK_LIMIT_CH1_RST;
      cfg_r.color_valid_max <= lsfp_pkg::COLOR_VALID_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsfp_pkg::CFG_GREEN_RATIO:     cfg_r.green_ratio     <= cfg_wdata[3:0];
        lsfp_pkg::CFG_BLACK_LIMIT_CH0: cfg_r.black_limit_ch0 <= cfg_wdata[9:0];
        lsfp_pkg::CFG_BLACK_LIMIT_CH1: cfg_r.black_limit_ch1 <= cfg_wdata[9:0];
        lsfp_pkg::CFG_COLOR_VALID_MAX: cfg_r.color_valid_max <= cfg_wdata[14:0];
      endcase
    end
  end

  lsfp_front #(
    .REFLECTOR_COUNT (REFLECTOR_COUNT),
    .MAX_TOKENS      (MAX_TOKENS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg        (cfg_r),
    .q_status   (q_status),
    .refl_store (refl_store),
    .color_ch   (color_ch),
    .tick_count (tick_count),
    .line_done  (line_done)
  );

  lsfp_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_done  (line_done),
    .color_ch   (color_ch),
    .tick_count (tick_count),
    .cfg        (cfg_r),
    .push       (push),
    .push_color (push_color)
  );

  lsfp_queue #(
    .REFLECTOR_COUNT (REFLECTOR_COUNT)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_refl  (refl_store),
    .push_color (push_color),
    .pop        (pop),
    .refl_sel   (refl_sel),
    .head_refl  (head_refl),
    .head_color (head_color),
    .q_status   (q_status)
  );

  lsfp_back #(
    .REFLECTOR_COUNT (REFLECTOR_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_bus    (out_bus),
    .q_status   (q_status),
    .head_refl  (head_refl),
    .head_color (head_color),
    .pop        (pop),
    .refl_sel   (refl_sel)
  );

endmodule

`default_nettype wire
